/* rtl/pde_pkg.sv */
// Shared types, constants and helpers for the particle drag Euler step unit.
package pde_pkg;

  localparam int SQRT_STEPS = 32;
  localparam int PDE_LATENCY = 2 + SQRT_STEPS + 3 + 4;

  localparam logic [29:0] Q_ONE_TENTH = 30'd6554;
  localparam logic [29:0] ROUND_HALF  = 30'd32768;
  localparam logic [32:0] MAG_LIMIT   = 33'h1_0000_0000;

  typedef enum logic [1:0] {
    REG_BASE_X = 2'd0,
    REG_BASE_Y = 2'd1,
    REG_BASE_Z = 2'd2
  } pde_reg_t;

  localparam logic signed [31:0] BASE_X_RST = 32'sd0;
  localparam logic signed [31:0] BASE_Y_RST = -32'sd13107;
  localparam logic signed [31:0] BASE_Z_RST = 32'sd0;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [16:0]      damp;
    logic [13:0]      dt;
    logic             last;
  } pde_item_t;

  function automatic logic [31:0] sat32(input logic signed [34:0] v);
    logic [31:0] r;
    if (v > 35'sh0_7FFF_FFFF) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -35'sh0_8000_0000) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* rtl/particle_drag_euler_step_unit.sv */
// Top level of the particle drag Euler step unit.
// One particle enters per beat: start high while busy is low accepts the
// position, velocity, drag coefficient, time step and frame marker.
// The unit computes quadratic drag from the speed, adds the base
// acceleration, and steps velocity, then position from the new velocity,
// by semi-implicit Euler, saturating to Q16.16. Each accepted beat gives
// exactly one result beat; done is high for a single cycle with each beat.
// Throughput is one particle per clock outside reset; the 32-stage square
// root of the squared speed sets most of the latency.
// The user writes the base acceleration registers via cfg_we, cfg_addr and
// cfg_wdata only while no particle is in flight; nothing here enforces it.
// Synchronous reset empties the pipeline and restores the base acceleration
// to zero with gravity of about -0.2 on y. busy is high only during reset.
// The receiver cannot stall; results must be taken in the cycle they show.
module particle_drag_euler_step_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] pos_x,
  input  logic [31:0] pos_y,
  input  logic [31:0] pos_z,
  input  logic [31:0] vel_x,
  input  logic [31:0] vel_y,
  input  logic [31:0] vel_z,
  input  logic [16:0] drag_coeff,
  input  logic [16:0] time_step,
  input  logic        last_in_frame,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  output logic        done,
  output logic [31:0] new_pos_x,
  output logic [31:0] new_pos_y,
  output logic [31:0] new_pos_z,
  output logic [31:0] new_vel_x,
  output logic [31:0] new_vel_y,
  output logic [31:0] new_vel_z,
  output logic        below_floor,
  output logic        frame_end
);
  import pde_pkg::*;

  logic [2:0][31:0] base;
  logic             accept;
  logic             v0, v1, sq_valid, dr_valid;
  pde_item_t        in_item, item0, item1, sq_item, dr_item;
  logic [2:0][63:0] sq0;
  logic [63:0]      sumsq;
  logic [31:0]      speed;
  logic [2:0][31:0] acc, npos, nvel;
  logic [29:0]      dt_prod;

  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      base[0] <= BASE_X_RST;
      base[1] <= BASE_Y_RST;
      base[2] <= BASE_Z_RST;
    end else if (cfg_we) begin
      unique case (pde_reg_t'(cfg_addr))
        REG_BASE_X: base[0] <= cfg_wdata;
        REG_BASE_Y: base[1] <= cfg_wdata;
        REG_BASE_Z: base[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign dt_prod = 30'(time_step) * Q_ONE_TENTH + ROUND_HALF;

  always_comb begin
    in_item.pos  = {pos_z, pos_y, pos_x};
    in_item.vel  = {vel_z, vel_y, vel_x};
    in_item.damp = drag_coeff;
    in_item.dt   = dt_prod[29:16];
    in_item.last = last_in_frame;
  end

  for (genvar i = 0; i < 3; i++) begin : g_sq
    logic [31:0] absv;
    assign absv = in_item.vel[i][31] ? (32'd0 - in_item.vel[i]) : in_item.vel[i];
    always_ff @(posedge clk) begin
      sq0[i] <= 64'(absv) * 64'(absv);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      v0 <= accept;
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    item0 <= in_item;
    item1 <= item0;
    sumsq <= sq0[0] + sq0[1] + sq0[2];
  end

  pde_isqrt u_isqrt (
    .clk(clk), .rst(rst), .in_valid(v1), .radicand(sumsq), .in_item(item1),
    .out_valid(sq_valid), .root(speed), .out_item(sq_item)
  );

  pde_drag u_drag (
    .clk(clk), .rst(rst), .in_valid(sq_valid), .speed(speed), .in_item(sq_item),
    .base(base), .out_valid(dr_valid), .acc(acc), .out_item(dr_item)
  );

  pde_integ u_integ (
    .clk(clk), .rst(rst), .in_valid(dr_valid), .acc(acc), .in_item(dr_item),
    .out_valid(done), .new_pos(npos), .new_vel(nvel),
    .below_floor(below_floor), .frame_end(frame_end)
  );

  assign new_pos_x = npos[0];
  assign new_pos_y = npos[1];
  assign new_pos_z = npos[2];
  assign new_vel_x = nvel[0];
  assign new_vel_y = nvel[1];
  assign new_vel_z = nvel[2];
endmodule

/* rtl/pde_isqrt.sv */
// Fully pipelined 64-bit integer square root, one result bit per stage.
module pde_isqrt (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [63:0]          radicand,
  input  pde_pkg::pde_item_t   in_item,
  output logic                 out_valid,
  output logic [31:0]          root,
  output pde_pkg::pde_item_t   out_item
);
  import pde_pkg::*;

  logic [63:0] rem  [0:SQRT_STEPS];
  logic [63:0] res  [0:SQRT_STEPS];
  logic        vld  [0:SQRT_STEPS];
  pde_item_t   item [0:SQRT_STEPS];

  assign rem[0]  = radicand;
  assign res[0]  = 64'd0;
  assign vld[0]  = in_valid;
  assign item[0] = in_item;

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
    logic [63:0] trial;
    assign trial = res[j] + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      item[j+1] <= item[j];
      if (rem[j] >= trial) begin
        rem[j+1] <= rem[j] - trial;
        res[j+1] <= (res[j] >> 1) + BIT;
      end else begin
        rem[j+1] <= rem[j];
        res[j+1] <= res[j] >> 1;
      end
    end
  end

  assign out_valid = vld[SQRT_STEPS];
  assign root      = res[SQRT_STEPS][31:0];
  assign out_item  = item[SQRT_STEPS];
endmodule

/* rtl/pde_drag.sv */
// Quadratic drag and saturated acceleration, three pipeline stages.
module pde_drag (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [31:0]          speed,
  input  pde_pkg::pde_item_t   in_item,
  input  logic [2:0][31:0]     base,
  output logic                 out_valid,
  output logic [2:0][31:0]     acc,
  output pde_pkg::pde_item_t   out_item
);
  import pde_pkg::*;

  logic             v1, v2;
  pde_item_t        item1, item2;
  logic [2:0][47:0] prod1;
  logic [2:0][40:0] hi2, lo2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    logic [31:0]        absv;
    logic [63:0]        p;
    logic [64:0]        full;
    logic [48:0]        mag;
    logic [32:0]        magc;
    logic signed [34:0] dm, drag;

    assign absv = in_item.vel[i][31] ? (32'd0 - in_item.vel[i]) : in_item.vel[i];
    assign p    = 64'(absv) * 64'(speed);
    assign full = {hi2[i], 24'd0} + 65'(lo2[i]);
    assign mag  = full[64:16];
    // Any drag of 2^32 or more saturates the acceleration the same way.
    assign magc = (mag > 49'(MAG_LIMIT)) ? MAG_LIMIT : mag[32:0];
    assign dm   = $signed({2'b00, magc});
    assign drag = item2.vel[i][31] ? dm : -dm;

    always_ff @(posedge clk) begin
      prod1[i] <= p[63:16];
      hi2[i]   <= 41'(prod1[i][47:24]) * 41'(item1.damp);
      lo2[i]   <= 41'(prod1[i][23:0]) * 41'(item1.damp);
      acc[i]   <= sat32(35'($signed(base[i])) + drag);
    end
  end

  always_ff @(posedge clk) begin
    item1    <= in_item;
    item2    <= item1;
    out_item <= item2;
  end
endmodule

/* rtl/pde_integ.sv */
// Euler update of velocity and then position, four pipeline stages.
module pde_integ (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [2:0][31:0]     acc,
  input  pde_pkg::pde_item_t   in_item,
  output logic                 out_valid,
  output logic [2:0][31:0]     new_pos,
  output logic [2:0][31:0]     new_vel,
  output logic                 below_floor,
  output logic                 frame_end
);
  import pde_pkg::*;

  logic             v1, v2, v3;
  pde_item_t        item1, item2, item3;
  logic [2:0][46:0] pa1, pb3;
  logic [2:0][31:0] nv2, nv3;
  logic [2:0][31:0] np;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    logic signed [46:0] pa, pb, sa, sb;
    logic signed [34:0] vsum, psum;

    assign pa   = $signed(acc[i]) * $signed({1'b0, in_item.dt});
    assign pb   = $signed(nv2[i]) * $signed({1'b0, item2.dt});
    // Arithmetic shifts give the floor of the scaled products.
    assign sa   = $signed(pa1[i]) >>> 16;
    assign sb   = $signed(pb3[i]) >>> 16;
    assign vsum = 35'($signed(item1.vel[i])) + 35'(sa);
    assign psum = 35'($signed(item3.pos[i])) + 35'(sb);
    assign np[i] = sat32(psum);

    always_ff @(posedge clk) begin
      pa1[i]     <= pa;
      nv2[i]     <= sat32(vsum);
      nv3[i]     <= nv2[i];
      pb3[i]     <= pb;
      new_pos[i] <= np[i];
      new_vel[i] <= nv3[i];
    end
  end

  always_ff @(posedge clk) begin
    item1       <= in_item;
    item2       <= item1;
    item3       <= item2;
    below_floor <= np[1][31];
    frame_end   <= item3.last;
  end
endmodule

/* rtl/pde_checker.sv */
// Port-level assertions for the particle drag Euler step unit, with bind.
module pde_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        last_in_frame,
  input logic        done,
  input logic [31:0] new_pos_y,
  input logic        below_floor,
  input logic        frame_end
);
  import pde_pkg::*;

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PDE_LATENCY))
    else $error("result beat without a matching accepted beat");

  a_frame_mark: assert property (@(posedge clk) disable iff (rst)
    done |-> (frame_end == $past(last_in_frame, PDE_LATENCY)))
    else $error("frame marker did not follow its particle");

  a_floor_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (below_floor == new_pos_y[31]))
    else $error("below_floor disagrees with new height sign");

  a_ready: assert property (@(posedge clk) !rst |-> !busy)
    else $error("busy raised outside reset");
endmodule

bind particle_drag_euler_step_unit pde_checker u_pde_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .last_in_frame(last_in_frame),
  .done(done), .new_pos_y(new_pos_y), .below_floor(below_floor), .frame_end(frame_end)
);

/* tb/sv/particle_drag_euler_step_unit_tb.sv */
// Self-checking testbench for the particle drag Euler step unit.
module particle_drag_euler_step_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pde_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;  // no register at this index
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [31:0] pos [3];
    logic [31:0] vel [3];
    logic [16:0] drag;
    logic [16:0] tstep;
    logic        last;
  } particle_t;

  typedef struct {
    logic [31:0] pos [3];
    logic [31:0] vel [3];
    logic        below;
    logic        fend;
  } step_out_t;

  logic clk, rst, start, busy, cfg_we, done, below_floor, frame_end;
  logic [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, cfg_wdata;
  logic [31:0] new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z;
  logic [16:0] drag_coeff, time_step;
  logic        last_in_frame;
  logic [1:0]  cfg_addr;

  particle_drag_euler_step_unit dut (.*);

  particle_t   particle_q [$];
  step_out_t   step_q [$];
  particle_t   on_port;
  logic signed [31:0] accel [3];
  int n_sent, n_checked, n_errors, cycles, burst_left, gap_left;
  bit hold;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic step_out_t euler_step(input particle_t p);
    step_out_t r;
    longint vel [3], pos, acc, nv, np, drg;
    logic [63:0] mag_v [3], sq, speed, mag, dt;
    dt = ({47'd0, p.tstep} * 64'd6554 + 64'd32768) >> 16;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      vel[i] = longint'(signed'(p.vel[i]));
      mag_v[i] = (vel[i] < 0) ? -vel[i] : vel[i];
      sq += mag_v[i] * mag_v[i];
    end
    speed = int_sqrt(sq);
    for (int i = 0; i < 3; i++) begin
      mag = (((mag_v[i] * speed) >> 16) * {47'd0, p.drag}) >> 16;
      if (mag > 64'h1_0000_0000) mag = 64'h1_0000_0000;
      drg = (vel[i] < 0) ? longint'(mag) : -longint'(mag);
      acc = clamp32(longint'(accel[i]) + drg);
      // Arithmetic shift of a signed product rounds toward minus infinity.
      nv = clamp32(vel[i] + ((acc * longint'(dt)) >>> 16));
      pos = longint'(signed'(p.pos[i]));
      np = clamp32(pos + ((nv * longint'(dt)) >>> 16));
      r.pos[i] = np[31:0];
      r.vel[i] = nv[31:0];
    end
    r.below = r.pos[1][31];
    r.fend = p.last;
    return r;
  endfunction

  // Driver: bursts of beats with random gaps between them.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        step_q.push_back(euler_step(on_port));
        n_sent++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (!hold && particle_q.size() != 0) begin
          on_port = particle_q.pop_front();
          pos_x <= on_port.pos[0];
          pos_y <= on_port.pos[1];
          pos_z <= on_port.pos[2];
          vel_x <= on_port.vel[0];
          vel_y <= on_port.vel[1];
          vel_z <= on_port.vel[2];
          drag_coeff <= on_port.drag;
          time_step <= on_port.tstep;
          last_in_frame <= on_port.last;
          start <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every done beat must match the oldest prediction.
  always @(posedge clk) begin
    step_out_t e;
    logic [31:0] got_pos [3], got_vel [3];
    bit bad;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
    if (!rst && done) begin
      got_pos = '{new_pos_x, new_pos_y, new_pos_z};
      got_vel = '{new_vel_x, new_vel_y, new_vel_z};
      if (step_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result beat at cycle %0d", cycles);
      end else begin
        e = step_q.pop_front();
        n_checked++;
        bad = (below_floor !== e.below) || (frame_end !== e.fend);
        for (int i = 0; i < 3; i++)
          bad |= (got_pos[i] !== e.pos[i]) || (got_vel[i] !== e.vel[i]);
        if (bad) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch beat %0d: exp pos %h %h %h vel %h %h %h bf %b fe %b",
                     n_checked, e.pos[0], e.pos[1], e.pos[2], e.vel[0], e.vel[1],
                     e.vel[2], e.below, e.fend,
                     "\n   got pos %h %h %h vel %h %h %h bf %b fe %b",
                     new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
                     new_vel_z, below_floor, frame_end);
        end
      end
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2, 3: return 32'(signed'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic particle_t rand_particle();
    particle_t p;
    for (int i = 0; i < 3; i++) begin
      p.pos[i] = rand_word();
      p.vel[i] = rand_word();
    end
    p.drag = ($urandom_range(0, 2) == 0) ? 17'($urandom) : 17'($urandom_range(0, 16384));
    p.tstep = ($urandom_range(0, 2) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
    p.last = ($urandom_range(0, 15) == 0);
    return p;
  endfunction

  function automatic particle_t make_particle(input logic [31:0] px, py, pz, vx, vy, vz,
                                              input logic [16:0] dr, ts, input logic lf);
    particle_t p;
    p.pos = '{px, py, pz};
    p.vel = '{vx, vy, vz};
    p.drag = dr;
    p.tstep = ts;
    p.last = lf;
    return p;
  endfunction

  task automatic drain();
    wait (particle_q.size() == 0 && n_checked == n_sent && !start);
    repeat (PDE_LATENCY + 8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx != REG_UNUSED) accel[idx] = val;
  endtask

  task automatic random_phase(input int n);
    repeat (n) particle_q.push_back(rand_particle());
    drain();
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = REG_BASE_X;
    cfg_wdata = '0;
    {pos_x, pos_y, pos_z, vel_x, vel_y, vel_z} = '0;
    drag_coeff = '0;
    time_step = '0;
    last_in_frame = 1'b0;
    accel = '{BASE_X_RST, BASE_Y_RST, BASE_Z_RST};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed beats at the reset acceleration.
    particle_q.push_back(make_particle(0, 32'h0001_0000, 0, 0, 0, 0, 17'h1FFFF, 17'd65536, 0));
    particle_q.push_back(make_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 17'h1FFFF, 17'h1FFFF, 1));
    particle_q.push_back(make_particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
        32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 17'h1FFFF, 17'h1FFFF, 0));
    particle_q.push_back(make_particle(5, 10, 15, 32'h0002_0000, 32'hFFFE_0000,
        32'h8000_0000, 0, 17'd65536, 1));
    particle_q.push_back(make_particle(1, 32'd100, 2, 32'h0001_0000, 32'hFFFF_0000, 7,
        17'd6554, 0, 0));
    particle_q.push_back(make_particle(0, 32'd5, 0, 0, 32'hFFF0_0000, 0, 17'd100, 17'd65536, 0));
    particle_q.push_back(make_particle(32'h7FFF_0000, 0, 32'h8001_0000, 32'h7FFF_FFFF, 0,
        32'h8000_0000, 0, 17'h1FFFF, 1));
    particle_q.push_back(make_particle(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'd1, 17'd1, 0));
    particle_q.push_back(make_particle(0, 0, 0, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001,
        17'h10000, 17'h10000, 1));
    drain();
    random_phase(130);

    write_reg(REG_BASE_X, 32'h7FFF_FFFF);
    write_reg(REG_BASE_Y, 32'h7FFF_FFFF);
    write_reg(REG_BASE_Z, 32'h7FFF_FFFF);
    random_phase(130);

    write_reg(REG_BASE_X, 32'h8000_0000);
    write_reg(REG_BASE_Y, 32'h8000_0000);
    write_reg(REG_BASE_Z, 32'h8000_0000);
    random_phase(130);

    // A write to the unused index must leave all three registers alone.
    write_reg(REG_BASE_X, 32'h0000_8000);
    write_reg(REG_BASE_Y, 32'hFFF6_0000);
    write_reg(REG_BASE_Z, 32'hFFFF_C000);
    write_reg(REG_UNUSED, 32'h1234_5678);
    random_phase(150);

    // The sender holds off mid-phase until every result has come back.
    write_reg(REG_BASE_X, $urandom);
    write_reg(REG_BASE_Y, $urandom);
    write_reg(REG_BASE_Z, $urandom);
    hold = 1'b1;
    repeat (100) particle_q.push_back(rand_particle());
    hold = 1'b0;
    wait (particle_q.size() < 50);
    hold = 1'b1;
    wait (n_checked == n_sent && !start);
    hold = 1'b0;
    drain();

    write_reg(REG_BASE_X, 32'd0);
    write_reg(REG_BASE_Y, 32'sd0 - 32'sd13107);
    write_reg(REG_BASE_Z, 32'd0);
    random_phase(200);

    if (n_errors == 0 && step_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
